>>> rtl/modbus_register_map_server_core_macros.svh
// assertion helpers for the register map server
`ifndef MODBUS_REGISTER_MAP_SERVER_CORE_MACROS_SVH
`define MODBUS_REGISTER_MAP_SERVER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MBRM_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("register map check failed");

// next-cycle implication, disabled during reset
`define MBRM_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("register map check failed");

`endif

>>> rtl/mbrm_pkg.sv
package mbrm_pkg;

  // store depths
  localparam int COIL_DEPTH      = 256;
  localparam int DISCRETE_DEPTH  = 256;
  localparam int INPUT_REG_DEPTH = 64;
  localparam int HOLD_REG_DEPTH  = 64;

  localparam int COIL_AW     = (COIL_DEPTH > 1) ? $clog2(COIL_DEPTH) : 1;
  localparam int DISCRETE_AW = (DISCRETE_DEPTH > 1) ? $clog2(DISCRETE_DEPTH) : 1;
  localparam int INPUT_AW    = (INPUT_REG_DEPTH > 1) ? $clog2(INPUT_REG_DEPTH) : 1;
  localparam int HOLD_AW     = (HOLD_REG_DEPTH > 1) ? $clog2(HOLD_REG_DEPTH) : 1;

  localparam int BIT_AW = (COIL_AW > DISCRETE_AW) ? COIL_AW : DISCRETE_AW;
  localparam int REG_AW = (INPUT_AW > HOLD_AW) ? INPUT_AW : HOLD_AW;
  localparam int IDX_W  = (BIT_AW > REG_AW) ? BIT_AW : REG_AW;

  // clearing pass after reset covers the deepest store
  localparam int BIT_DEPTH = (COIL_DEPTH > DISCRETE_DEPTH) ? COIL_DEPTH : DISCRETE_DEPTH;
  localparam int REG_DEPTH = (INPUT_REG_DEPTH > HOLD_REG_DEPTH) ? INPUT_REG_DEPTH
                                                                : HOLD_REG_DEPTH;
  localparam int CLR_DEPTH = (BIT_DEPTH > REG_DEPTH) ? BIT_DEPTH : REG_DEPTH;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  // field widths
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 16;
  localparam int QTY_W   = 11;
  localparam int BYTES_W = 8;
  localparam int BITCNT_W = 9;
  localparam int REGCNT_W = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  // byte count arithmetic
  localparam int QCHK_W      = 12;
  localparam int BYTE_ROUND  = 7;
  localparam int BYTE_SHIFT  = 3;

  // element queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COIL_COUNT     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCRETE_COUNT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNT     = 4'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd1;
  localparam logic [1:0] ST_BAD_VALUE = 2'd2;

  typedef enum logic [2:0] {
    ACT_RD_COIL     = 3'd0,
    ACT_RD_DISCRETE = 3'd1,
    ACT_RD_HOLD     = 3'd2,
    ACT_RD_INPUT    = 3'd3,
    ACT_WR_COIL     = 3'd4,
    ACT_WR_HOLD     = 3'd5,
    ACT_SET_DISCRETE = 3'd6,
    ACT_SET_INPUT   = 3'd7
  } action_t;

  // classified element passed from front to back
  typedef struct packed {
    action_t           action;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
    logic              first;
    logic              in_range;
    logic              bad_value;
    logic              last;
  } op_t;

endpackage

>>> rtl/mbrm_req_if.sv
interface mbrm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] address;
  logic [15:0] value;
  logic        first;
  logic        multiple;
  logic [10:0] quantity;
  logic [7:0]  byte_count;
  logic        last;

  modport source (
    output valid, action, address, value, first, multiple, quantity, byte_count, last,
    input  ready
  );
  modport sink (
    input  valid, action, address, value, first, multiple, quantity, byte_count, last,
    output ready
  );
endinterface

>>> rtl/mbrm_rsp_if.sv
interface mbrm_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic [1:0]  status;
  logic        last_out;

  modport source (
    output valid, read_value, status, last_out,
    input  ready
  );
  modport sink (
    input  valid, read_value, status, last_out,
    output ready
  );
endinterface

>>> rtl/mbrm_ram.sv
module mbrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/mbrm_front.sv
module mbrm_front (
  mbrm_req_if.sink                              req,
  input  logic [mbrm_pkg::BITCNT_W-1:0]         coil_count,
  input  logic [mbrm_pkg::BITCNT_W-1:0]         discrete_count,
  input  logic [mbrm_pkg::REGCNT_W-1:0]         input_reg_count,
  input  logic [mbrm_pkg::REGCNT_W-1:0]         hold_reg_count,
  input  logic                                  q_full,
  output logic                                  push,
  output mbrm_pkg::op_t                         op
);

  mbrm_pkg::action_t                 act;
  logic [mbrm_pkg::ADDR_W-1:0]       cnt;
  logic [mbrm_pkg::ADDR_W-1:0]       depth;
  logic [mbrm_pkg::QCHK_W-1:0]       coil_bytes;
  logic [mbrm_pkg::QCHK_W-1:0]       hold_bytes;
  logic [mbrm_pkg::QCHK_W-1:0]       bytes_ext;
  logic                              mismatch;

  assign act = mbrm_pkg::action_t'(req.action);

  // accept whenever the queue has room
  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  // count and depth of the addressed store
  always_comb begin
    unique case (act)
      mbrm_pkg::ACT_RD_COIL, mbrm_pkg::ACT_WR_COIL: begin
        cnt   = mbrm_pkg::ADDR_W'(coil_count);
        depth = mbrm_pkg::ADDR_W'(mbrm_pkg::COIL_DEPTH);
      end
      mbrm_pkg::ACT_RD_DISCRETE, mbrm_pkg::ACT_SET_DISCRETE: begin
        cnt   = mbrm_pkg::ADDR_W'(discrete_count);
        depth = mbrm_pkg::ADDR_W'(mbrm_pkg::DISCRETE_DEPTH);
      end
      mbrm_pkg::ACT_RD_INPUT, mbrm_pkg::ACT_SET_INPUT: begin
        cnt   = mbrm_pkg::ADDR_W'(input_reg_count);
        depth = mbrm_pkg::ADDR_W'(mbrm_pkg::INPUT_REG_DEPTH);
      end
      default: begin
        cnt   = mbrm_pkg::ADDR_W'(hold_reg_count);
        depth = mbrm_pkg::ADDR_W'(mbrm_pkg::HOLD_REG_DEPTH);
      end
    endcase
  end

  // byte count check for multiple writes
  assign coil_bytes = (mbrm_pkg::QCHK_W'(req.quantity) + mbrm_pkg::QCHK_W'(mbrm_pkg::BYTE_ROUND))
                      >> mbrm_pkg::BYTE_SHIFT;
  assign hold_bytes = {req.quantity, 1'b0};
  assign bytes_ext  = mbrm_pkg::QCHK_W'(req.byte_count);

  always_comb begin
    unique case (act)
      mbrm_pkg::ACT_WR_COIL: mismatch = (coil_bytes != bytes_ext);
      mbrm_pkg::ACT_WR_HOLD: mismatch = (hold_bytes != bytes_ext);
      default:               mismatch = 1'b0;
    endcase
  end

  // classified element
  always_comb begin
    op.action    = act;
    op.index     = req.address[mbrm_pkg::IDX_W-1:0];
    op.value     = req.value;
    op.first     = req.first;
    op.in_range  = (req.address < cnt) && (req.address < depth);
    op.bad_value = req.first && req.multiple && mismatch;
    op.last      = req.last;
  end

endmodule

>>> rtl/mbrm_queue.sv
module mbrm_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  mbrm_pkg::op_t               op_in,
  input  logic                        pop,
  output mbrm_pkg::op_t               head,
  output logic                        empty,
  output logic                        full,
  output logic [mbrm_pkg::Q_CW-1:0]   count
);

  mbrm_pkg::op_t               entries [mbrm_pkg::Q_DEPTH];
  logic [mbrm_pkg::Q_AW-1:0]   wr_ptr;
  logic [mbrm_pkg::Q_AW-1:0]   rd_ptr;

  assign empty = (count == '0);
  assign full  = (count == mbrm_pkg::Q_CW'(mbrm_pkg::Q_DEPTH));
  assign head  = entries[rd_ptr];

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mbrm_pkg::Q_AW'(mbrm_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mbrm_pkg::Q_AW'(mbrm_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= op_in;
    end
  end

endmodule

>>> rtl/mbrm_back.sv
module mbrm_back (
  input  logic          clk,
  input  logic          rst,
  input  mbrm_pkg::op_t head,
  input  logic          empty,
  output logic          pop,
  mbrm_rsp_if.source    rsp
);

  logic [1:0]        latch;
  logic [1:0]        latch_eff;
  logic [1:0]        st;
  logic              do_op;
  logic              issue;

  logic              coil_we, coil_re, disc_we, disc_re;
  logic              inp_we, inp_re, hold_we, hold_re;
  logic              coil_q, disc_q;
  logic [mbrm_pkg::DATA_W-1:0] inp_q, hold_q;

  logic                         clearing;
  logic [mbrm_pkg::CLR_W-1:0]   clr_idx;
  logic                         bit_wdata;
  logic [mbrm_pkg::DATA_W-1:0]  reg_wdata;

  logic [mbrm_pkg::COIL_AW-1:0]     coil_idx;
  logic [mbrm_pkg::DISCRETE_AW-1:0] disc_idx;
  logic [mbrm_pkg::INPUT_AW-1:0]    inp_idx;
  logic [mbrm_pkg::HOLD_AW-1:0]     hold_idx;

  logic [mbrm_pkg::COIL_AW-1:0]     coil_addr;
  logic [mbrm_pkg::DISCRETE_AW-1:0] disc_addr;
  logic [mbrm_pkg::INPUT_AW-1:0]    inp_addr;
  logic [mbrm_pkg::HOLD_AW-1:0]     hold_addr;

  mbrm_pkg::action_t out_act;
  logic              out_rd;
  logic [mbrm_pkg::DATA_W-1:0] rd_mux;

  assign coil_idx = head.index[mbrm_pkg::COIL_AW-1:0];
  assign disc_idx = head.index[mbrm_pkg::DISCRETE_AW-1:0];
  assign inp_idx  = head.index[mbrm_pkg::INPUT_AW-1:0];
  assign hold_idx = head.index[mbrm_pkg::HOLD_AW-1:0];

  // clearing pass after reset, one entry of every store per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == mbrm_pkg::CLR_W'(mbrm_pkg::CLR_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // issue the head element when the output stage is free
  assign issue = !clearing && !empty && (!rsp.valid || rsp.ready);
  assign pop   = issue;

  // error latch handling, first element clears it
  always_comb begin
    latch_eff = head.first ? mbrm_pkg::ST_OK : latch;
    do_op     = 1'b0;
    if (latch_eff != mbrm_pkg::ST_OK) begin
      st = latch_eff;
    end else if (head.bad_value) begin
      st = mbrm_pkg::ST_BAD_VALUE;
    end else if (!head.in_range) begin
      st = mbrm_pkg::ST_BAD_ADDR;
    end else begin
      st    = mbrm_pkg::ST_OK;
      do_op = 1'b1;
    end
  end

  // store enables
  always_comb begin
    coil_we = 1'b0;
    coil_re = 1'b0;
    disc_we = 1'b0;
    disc_re = 1'b0;
    inp_we  = 1'b0;
    inp_re  = 1'b0;
    hold_we = 1'b0;
    hold_re = 1'b0;
    unique case (head.action)
      mbrm_pkg::ACT_RD_COIL:      coil_re = issue && do_op;
      mbrm_pkg::ACT_RD_DISCRETE:  disc_re = issue && do_op;
      mbrm_pkg::ACT_RD_HOLD:      hold_re = issue && do_op;
      mbrm_pkg::ACT_RD_INPUT:     inp_re  = issue && do_op;
      mbrm_pkg::ACT_WR_COIL:      coil_we = issue && do_op;
      mbrm_pkg::ACT_WR_HOLD:      hold_we = issue && do_op;
      mbrm_pkg::ACT_SET_DISCRETE: disc_we = issue && do_op;
      mbrm_pkg::ACT_SET_INPUT:    inp_we  = issue && do_op;
      default: ;
    endcase
  end

  // store ports, owned by the clearing pass until it ends
  assign coil_addr = clearing ? clr_idx[mbrm_pkg::COIL_AW-1:0] : coil_idx;
  assign disc_addr = clearing ? clr_idx[mbrm_pkg::DISCRETE_AW-1:0] : disc_idx;
  assign inp_addr  = clearing ? clr_idx[mbrm_pkg::INPUT_AW-1:0] : inp_idx;
  assign hold_addr = clearing ? clr_idx[mbrm_pkg::HOLD_AW-1:0] : hold_idx;
  assign bit_wdata = clearing ? 1'b0 : head.value[0];
  assign reg_wdata = clearing ? '0 : head.value;

  // the four stores
  mbrm_ram #(.WIDTH(1), .DEPTH(mbrm_pkg::COIL_DEPTH)) u_coil (
    .clk(clk), .we(coil_we || clearing), .re(coil_re), .addr(coil_addr),
    .wdata(bit_wdata), .rdata(coil_q)
  );
  mbrm_ram #(.WIDTH(1), .DEPTH(mbrm_pkg::DISCRETE_DEPTH)) u_disc (
    .clk(clk), .we(disc_we || clearing), .re(disc_re), .addr(disc_addr),
    .wdata(bit_wdata), .rdata(disc_q)
  );
  mbrm_ram #(.WIDTH(mbrm_pkg::DATA_W), .DEPTH(mbrm_pkg::INPUT_REG_DEPTH)) u_inp (
    .clk(clk), .we(inp_we || clearing), .re(inp_re), .addr(inp_addr),
    .wdata(reg_wdata), .rdata(inp_q)
  );
  mbrm_ram #(.WIDTH(mbrm_pkg::DATA_W), .DEPTH(mbrm_pkg::HOLD_REG_DEPTH)) u_hold (
    .clk(clk), .we(hold_we || clearing), .re(hold_re), .addr(hold_addr),
    .wdata(reg_wdata), .rdata(hold_q)
  );

  // latch and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      latch     <= mbrm_pkg::ST_OK;
      rsp.valid <= 1'b0;
    end else if (issue) begin
      latch     <= st;
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rsp.status   <= st;
      rsp.last_out <= head.last;
      out_act      <= head.action;
      out_rd       <= do_op;
    end
  end

  // read data select from the registered store outputs
  always_comb begin
    unique case (out_act)
      mbrm_pkg::ACT_RD_COIL:     rd_mux = mbrm_pkg::DATA_W'(coil_q);
      mbrm_pkg::ACT_RD_DISCRETE: rd_mux = mbrm_pkg::DATA_W'(disc_q);
      mbrm_pkg::ACT_RD_HOLD:     rd_mux = hold_q;
      mbrm_pkg::ACT_RD_INPUT:    rd_mux = inp_q;
      default:                   rd_mux = '0;
    endcase
  end

  assign rsp.read_value = out_rd ? rd_mux : '0;

endmodule

>>> rtl/modbus_register_map_server_core.sv
// Modbus data-model server: each accepted transaction is one element of a request
// (read, write, or local set on coils, discrete inputs, input or holding registers)
// and yields exactly one response transaction with read data, status and the last
// flag. Elements sustain one per clock while the response side is ready, set by the
// single access each store makes per element. An accepted element is written into the
// two-entry element queue and issued from it into the store read and the output
// register, which presents its response; while a response is held, two more elements
// fill the queue and then the request side stalls. After reset a clearing pass over
// the deepest store zeroes every store; elements are accepted until the queue is full,
// but none is issued before the pass ends. The user must write counts through the
// configuration port only while no element is in flight; the core does not enforce it.
`include "modbus_register_map_server_core_macros.svh"

module modbus_register_map_server_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mbrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbrm_pkg::CFG_DATA_W-1:0]  cfg_data,
  mbrm_req_if.sink                         req,
  mbrm_rsp_if.source                       rsp
);

  logic [mbrm_pkg::BITCNT_W-1:0] coil_count;
  logic [mbrm_pkg::BITCNT_W-1:0] discrete_count;
  logic [mbrm_pkg::REGCNT_W-1:0] input_reg_count;
  logic [mbrm_pkg::REGCNT_W-1:0] hold_reg_count;

  logic                        push;
  logic                        pop;
  logic                        q_empty;
  logic                        q_full;
  logic [mbrm_pkg::Q_CW-1:0]   q_count;
  mbrm_pkg::op_t               op;
  mbrm_pkg::op_t               head;
  logic                        rsp_has_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coil_count      <= '0;
      discrete_count  <= '0;
      input_reg_count <= '0;
      hold_reg_count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbrm_pkg::CFG_COIL_COUNT:     coil_count      <= cfg_data;
        mbrm_pkg::CFG_DISCRETE_COUNT: discrete_count  <= cfg_data;
        mbrm_pkg::CFG_INPUT_COUNT:    input_reg_count <= cfg_data[mbrm_pkg::REGCNT_W-1:0];
        mbrm_pkg::CFG_HOLD_COUNT:     hold_reg_count  <= cfg_data[mbrm_pkg::REGCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // classify incoming elements
  mbrm_front u_front (
    .req             (req),
    .coil_count      (coil_count),
    .discrete_count  (discrete_count),
    .input_reg_count (input_reg_count),
    .hold_reg_count  (hold_reg_count),
    .q_full          (q_full),
    .push            (push),
    .op              (op)
  );

  // element queue
  mbrm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .op_in (op),
    .pop   (pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full),
    .count (q_count)
  );

  // store access and response
  mbrm_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (q_empty),
    .pop   (pop),
    .rsp   (rsp)
  );

  // checks
  assign rsp_has_data = rsp.valid && (rsp.read_value != '0);

  `MBRM_ASSERT_NEXT(a_accept_queued, clk, rst, req.valid && req.ready, q_count != '0)
  `MBRM_ASSERT_NOW(a_read_only_ok, clk, rst, rsp_has_data, rsp.status == mbrm_pkg::ST_OK)
  `MBRM_ASSERT_NOW(a_status_code, clk, rst, rsp.valid, rsp.status != 2'd3)

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mbrm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PIPE_SETTLE = 4;

  typedef struct {
    action_t     action;
    logic [15:0] address;
    logic [15:0] value;
    logic        first;
    logic        multiple;
    logic [10:0] quantity;
    logic [7:0]  byte_count;
    logic        last;
  } element_t;

  typedef struct {
    logic [15:0] read_value;
    logic [1:0]  status;
    logic        last_out;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mbrm_req_if req ();
  mbrm_rsp_if rsp ();

  modbus_register_map_server_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the register map
  logic        coil_map     [COIL_DEPTH]      = '{default: 1'b0};
  logic        discrete_map [DISCRETE_DEPTH]  = '{default: 1'b0};
  logic [15:0] input_regs   [INPUT_REG_DEPTH] = '{default: 16'h0};
  logic [15:0] holding_regs [HOLD_REG_DEPTH]  = '{default: 16'h0};
  logic [1:0]  request_fault = ST_OK;
  logic [8:0]  coil_total     = '0;
  logic [8:0]  discrete_total = '0;
  logic [6:0]  input_total    = '0;
  logic [6:0]  hold_total     = '0;

  element_t    pending [$];
  reply_t      answers [$];
  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  logic        req_taken      = 1'b0;
  int unsigned req_gap        = 0;
  int unsigned rsp_stall      = 0;
  int unsigned req_idle_pct   = 0;
  int unsigned rsp_stall_pct  = 0;

  // number of elements in use for the store an action touches
  function automatic int unsigned span_of(action_t act);
    case (act)
      ACT_RD_COIL, ACT_WR_COIL:
        return (coil_total < COIL_DEPTH) ? coil_total : COIL_DEPTH;
      ACT_RD_DISCRETE, ACT_SET_DISCRETE:
        return (discrete_total < DISCRETE_DEPTH) ? discrete_total : DISCRETE_DEPTH;
      ACT_RD_INPUT, ACT_SET_INPUT:
        return (input_total < INPUT_REG_DEPTH) ? input_total : INPUT_REG_DEPTH;
      default:
        return (hold_total < HOLD_REG_DEPTH) ? hold_total : HOLD_REG_DEPTH;
    endcase
  endfunction

  // serve one element against the shadow map
  function automatic reply_t serve_element(element_t e);
    reply_t      r;
    logic [1:0]  verdict;
    int unsigned qty;
    int unsigned nbytes;
    r.read_value = '0;
    r.last_out   = e.last;
    verdict      = ST_OK;
    qty          = e.quantity;
    nbytes       = e.byte_count;
    if (e.first) request_fault = ST_OK;
    // byte count only checked on the opening element of a multiple write
    if (request_fault == ST_OK && e.first && e.multiple) begin
      if (e.action == ACT_WR_COIL && (qty + 7) / 8 != nbytes) verdict = ST_BAD_VALUE;
      else if (e.action == ACT_WR_HOLD && qty * 2 != nbytes) verdict = ST_BAD_VALUE;
    end
    if (request_fault == ST_OK) begin
      if (verdict == ST_OK) begin
        if (e.address >= span_of(e.action)) begin
          verdict = ST_BAD_ADDR;
        end else begin
          case (e.action)
            ACT_RD_COIL:
              r.read_value = {15'b0, coil_map[e.address[COIL_AW-1:0]]};
            ACT_RD_DISCRETE:
              r.read_value = {15'b0, discrete_map[e.address[DISCRETE_AW-1:0]]};
            ACT_RD_HOLD:      r.read_value = holding_regs[e.address[HOLD_AW-1:0]];
            ACT_RD_INPUT:     r.read_value = input_regs[e.address[INPUT_AW-1:0]];
            ACT_WR_COIL:      coil_map[e.address[COIL_AW-1:0]] = e.value[0];
            ACT_WR_HOLD:      holding_regs[e.address[HOLD_AW-1:0]] = e.value;
            ACT_SET_DISCRETE: discrete_map[e.address[DISCRETE_AW-1:0]] = e.value[0];
            default:          input_regs[e.address[INPUT_AW-1:0]] = e.value;
          endcase
        end
      end
      request_fault = verdict;
    end
    r.status = request_fault;
    return r;
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endfunction

  // request and response monitor
  always @(posedge clk) begin : monitor
    element_t e;
    reply_t   want;
    req_taken = 1'b0;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected response transaction: status %h data %h",
                     rsp.status, rsp.read_value);
        end else begin
          want = answers.pop_front();
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("status", {14'b0, want.status}, {14'b0, rsp.status});
          check_field("last_out", {15'b0, want.last_out}, {15'b0, rsp.last_out});
        end
      end
      if (req.valid && req.ready) begin
        e.action     = action_t'(req.action);
        e.address    = req.address;
        e.value      = req.value;
        e.first      = req.first;
        e.multiple   = req.multiple;
        e.quantity   = req.quantity;
        e.byte_count = req.byte_count;
        e.last       = req.last;
        answers.push_back(serve_element(e));
        accepted_count++;
        req_taken = 1'b1;
      end
    end
  end

  // request driver with random idle bursts
  always @(negedge clk) begin : feeder
    element_t e;
    if (!rst && (!req.valid || req_taken)) begin
      if (req_gap != 0) begin
        req_gap   <= req_gap - 1;
        req.valid <= 1'b0;
      end else if (pending.size() != 0) begin
        e = pending.pop_front();
        req.valid      <= 1'b1;
        req.action     <= e.action;
        req.address    <= e.address;
        req.value      <= e.value;
        req.first      <= e.first;
        req.multiple   <= e.multiple;
        req.quantity   <= e.quantity;
        req.byte_count <= e.byte_count;
        req.last       <= e.last;
        if ($urandom_range(0, 99) < req_idle_pct) req_gap <= $urandom_range(1, 19);
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // response back-pressure in random bursts
  always @(negedge clk) begin
    if (rsp_stall != 0) begin
      rsp_stall <= rsp_stall - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
      if ($urandom_range(0, 99) < rsp_stall_pct) rsp_stall <= $urandom_range(1, 19);
    end
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_element(action_t act, logic [15:0] addr, logic [15:0] val,
                              logic first, logic multi, logic [10:0] qty,
                              logic [7:0] nbytes, logic last);
    element_t e;
    e.action     = act;
    e.address    = addr;
    e.value      = val;
    e.first      = first;
    e.multiple   = multi;
    e.quantity   = qty;
    e.byte_count = nbytes;
    e.last       = last;
    pending.push_back(e);
    queued_count++;
  endtask

  // a whole request over consecutive addresses, byte count right unless told otherwise
  task automatic queue_request(action_t act, int unsigned start, int unsigned n,
                               bit multi, bit good_bytes);
    logic [7:0] nbytes;
    if (!good_bytes) nbytes = 8'($urandom);
    else if (act == ACT_WR_COIL) nbytes = 8'((n + 7) / 8);
    else nbytes = 8'(n * 2);
    for (int k = 0; k < n; k++)
      push_element(act, 16'(start + k), 16'($urandom), k == 0, multi, 11'(n), nbytes,
                   k == n - 1);
  endtask

  // mostly well-formed requests with random content, the rest noise
  task automatic queue_random_items(int unsigned amount);
    int unsigned goal;
    int unsigned bound;
    int unsigned n;
    int unsigned start;
    action_t     act;
    goal = queued_count + amount;
    while (queued_count < goal) begin
      act = action_t'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 80) begin
        bound = span_of(act);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        if (bound != 0 && $urandom_range(0, 9) != 0) start = $urandom_range(0, bound - 1);
        else start = $urandom_range(0, 16'hFFFF);
        queue_request(act, start, n, 1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
      end else begin
        push_element(act, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                     11'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // wait until the pipe is empty
  task automatic settle();
    do @(negedge clk);
    while (accepted_count != queued_count || answers.size() != 0);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  task automatic write_count(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_COIL_COUNT:     coil_total     = data;
      CFG_DISCRETE_COUNT: discrete_total = data;
      CFG_INPUT_COUNT:    input_total    = data[6:0];
      CFG_HOLD_COUNT:     hold_total     = data[6:0];
      default: ;
    endcase
  endtask

  // reprogram all counts while idle, plus a write to an unused index
  task automatic set_counts(logic [8:0] coils, logic [8:0] discretes,
                            logic [8:0] inputs, logic [8:0] holds);
    settle();
    write_count(CFG_COIL_COUNT, coils);
    write_count(CFG_DISCRETE_COUNT, discretes);
    write_count(CFG_INPUT_COUNT, inputs);
    write_count(CFG_HOLD_COUNT, holds);
    write_count(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_HOLD_COUNT + 1)),
                CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [8:0] random_count(int unsigned depth);
    if ($urandom_range(0, 3) == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(1, depth));
  endfunction

  task automatic pick_pace();
    req_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
    rsp_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
  endtask

  initial begin : stimulus
    req.valid      = 1'b0;
    req.action     = ACT_RD_COIL;
    req.address    = '0;
    req.value      = '0;
    req.first      = 1'b0;
    req.multiple   = 1'b0;
    req.quantity   = '0;
    req.byte_count = '0;
    req.last       = 1'b0;
    rsp.ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // counts are zero out of reset, so every access is out of range
    push_element(ACT_RD_COIL, 16'h0000, 16'h0000, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_SET_INPUT, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);

    // directed pass with full depths
    set_counts(9'(COIL_DEPTH), 9'(DISCRETE_DEPTH), 9'(INPUT_REG_DEPTH), 9'(HOLD_REG_DEPTH));
    push_element(ACT_SET_DISCRETE, 16'd255, 16'hFFFF, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_SET_DISCRETE, 16'd0, 16'hFFFE, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_SET_INPUT, 16'd63, 16'hFFFF, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_SET_INPUT, 16'd0, 16'h8001, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_WR_COIL, 16'd255, 16'h0001, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_WR_HOLD, 16'd0, 16'hFFFF, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_WR_HOLD, 16'd63, 16'h5A5A, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_RD_DISCRETE, 16'd255, 16'h0000, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_RD_INPUT, 16'd63, 16'h0000, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_RD_COIL, 16'd255, 16'h0000, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_RD_HOLD, 16'd0, 16'h0000, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    // addresses just past the count and at the top of the field
    push_element(ACT_RD_HOLD, 16'd64, 16'h0000, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    push_element(ACT_RD_COIL, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 11'd1, 8'd0, 1'b1);
    // multiple coil write with a correct byte count
    queue_request(ACT_WR_COIL, 0, 3, 1'b1, 1'b1);
    // bad byte count on a holding write, the second element is skipped
    push_element(ACT_WR_HOLD, 16'd4, 16'h1234, 1'b1, 1'b1, 11'd2, 8'd3, 1'b0);
    push_element(ACT_WR_HOLD, 16'd5, 16'h4321, 1'b0, 1'b1, 11'd2, 8'd3, 1'b1);
    // read running off the end latches the error, the tail is skipped
    queue_request(ACT_RD_INPUT, 63, 3, 1'b0, 1'b1);
    // multiple flag on a read is ignored, and first clears the latch
    push_element(ACT_RD_HOLD, 16'd63, 16'h0000, 1'b1, 1'b1, 11'd5, 8'd0, 1'b1);
    // byte count extremes
    push_element(ACT_WR_HOLD, 16'd1, 16'hBEEF, 1'b1, 1'b1, 11'd0, 8'd0, 1'b1);
    push_element(ACT_WR_COIL, 16'd8, 16'h0001, 1'b1, 1'b1, 11'd2047, 8'd255, 1'b1);
    push_element(ACT_WR_HOLD, 16'd2, 16'h0F0F, 1'b1, 1'b1, 11'd127, 8'd254, 1'b1);

    // counts above the store depths, upper data bits on the register counts
    set_counts(9'h1FF, 9'd300, 9'h1FF, 9'h0C0);
    pick_pace();
    queue_random_items(200);

    for (int p = 0; p < 4; p++) begin
      set_counts(random_count(COIL_DEPTH), random_count(DISCRETE_DEPTH),
                 random_count(INPUT_REG_DEPTH), random_count(HOLD_REG_DEPTH));
      pick_pace();
      queue_random_items(200);
    end

    // smallest non-zero maps
    set_counts(9'd1, 9'd1, 9'd1, 9'd1);
    pick_pace();
    queue_random_items(100);

    // empty maps
    set_counts(9'd0, 9'd0, 9'd0, 9'd0);
    queue_random_items(30);

    // closing stretch at full rate on both sides
    set_counts(9'(COIL_DEPTH), 9'(DISCRETE_DEPTH), 9'(INPUT_REG_DEPTH), 9'(HOLD_REG_DEPTH));
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    queue_random_items(220);

    settle();
    if (mismatch_count == 0 && answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
